// ----- hdl/masked_pixel_to_yuyv_converter_defines.svh -----
// Assertion macros shared by the converter's checker
`ifndef MASKED_PIXEL_TO_YUYV_CONVERTER_DEFINES_SVH
`define MASKED_PIXEL_TO_YUYV_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MPY_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("converter port check failed");

// Next-cycle implication, sampled on clk, off during reset
`define MPY_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("converter port check failed");

`endif

// ----- hdl/mpyuyv_pkg.sv -----
// Shared types, register codes and helper functions of the pixel converter
package mpyuyv_pkg;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_BPP        = 3'd0;
    localparam logic [2:0] REG_BIG_ENDIAN = 3'd1;
    localparam logic [2:0] REG_RED_MASK   = 3'd2;
    localparam logic [2:0] REG_GREEN_MASK = 3'd3;
    localparam logic [2:0] REG_BLUE_MASK  = 3'd4;
    localparam logic [2:0] REG_FORMAT     = 3'd5;

    // Output format codes; the unused code behaves as RGB24
    localparam logic [1:0] FMT_YUYV  = 2'd0;
    localparam logic [1:0] FMT_RGB24 = 2'd1;
    localparam logic [1:0] FMT_BGR24 = 2'd2;

    localparam int AddrWidth = 5;

    typedef struct packed {
        logic [31:0] raw_first;
        logic [31:0] raw_second;
    } pixel_pair_t;

    typedef struct packed {
        logic [7:0] out_byte0;
        logic [7:0] out_byte1;
        logic [7:0] out_byte2;
        logic [7:0] out_byte3;
        logic [7:0] out_byte4;
        logic [7:0] out_byte5;
        logic [2:0] byte_count;
    } yuyv_result_t;

    // Configuration seen by the datapath, with precomputed mask shifts
    typedef struct packed {
        logic [2:0]  bytes_per_pixel;
        logic        big_endian;
        logic [31:0] red_bits;
        logic [31:0] green_bits;
        logic [31:0] blue_bits;
        logic [1:0]  output_format;
        logic [4:0]  red_tz;
        logic [4:0]  green_tz;
        logic [4:0]  blue_tz;
    } cfg_t;

    // Gather 0 to 4 bytes into a pixel word, reversed for big-endian
    function automatic logic [31:0] assemble(input logic [31:0] raw,
                                             input logic [2:0]  bpp,
                                             input logic        be);
        logic [2:0]  n;
        logic [1:0]  pos;
        logic [31:0] word;
        n    = (bpp > 3'd4) ? 3'd4 : bpp;
        word = '0;
        for (int b = 0; b < 4; b++)
        begin
            if (3'(b) < n)
            begin
                pos = be ? 2'(n - 3'd1 - 3'(b)) : 2'(b);
                word[b*8 +: 8] = raw[pos*8 +: 8];
            end
        end
        return word;
    endfunction

    // Count trailing zeros of a mask; zero for an empty mask
    function automatic logic [4:0] trailing_zeros(input logic [31:0] m);
        logic [4:0] s;
        s = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (m[i])
            begin
                s = 5'(i);
            end
        end
        return s;
    endfunction

    // Extract one 8-bit channel
    function automatic logic [7:0] channel(input logic [31:0] word,
                                           input logic [31:0] mask,
                                           input logic [4:0]  tz);
        logic [31:0] t;
        t = (word & mask) >> tz;
        return t[7:0];
    endfunction

    // Clamp a signed value to 0..255
    function automatic logic [7:0] clamp8(input logic signed [10:0] v);
        logic [7:0] r;
        if (v < 11'sd0)
        begin
            r = 8'd0;
        end
        else if (v > 11'sd255)
        begin
            r = 8'd255;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/mpyuyv_regs.sv -----
// APB register file holding the pixel layout and output format
module mpyuyv_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mpyuyv_pkg::AddrWidth-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output mpyuyv_pkg::cfg_t                 cfg
);

    mpyuyv_pkg::cfg_t cfg_reg;
    logic             wr_en;
    logic [2:0]       index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = paddr[4:2];
    assign cfg    = cfg_reg;

    // Write registers; derive mask shifts as the mask lands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bytes_per_pixel <= 3'd4;
            cfg_reg.big_endian      <= 1'b0;
            cfg_reg.red_bits        <= 32'h00FF_0000;
            cfg_reg.green_bits      <= 32'h0000_FF00;
            cfg_reg.blue_bits       <= 32'h0000_00FF;
            cfg_reg.output_format   <= mpyuyv_pkg::FMT_YUYV;
            cfg_reg.red_tz          <= 5'd16;
            cfg_reg.green_tz        <= 5'd8;
            cfg_reg.blue_tz         <= 5'd0;
        end
        else if (wr_en)
        begin
            case (index)
                mpyuyv_pkg::REG_BPP:
                begin
                    cfg_reg.bytes_per_pixel <= pwdata[2:0];
                end
                mpyuyv_pkg::REG_BIG_ENDIAN:
                begin
                    cfg_reg.big_endian <= pwdata[0];
                end
                mpyuyv_pkg::REG_RED_MASK:
                begin
                    cfg_reg.red_bits <= pwdata;
                    cfg_reg.red_tz   <= mpyuyv_pkg::trailing_zeros(pwdata);
                end
                mpyuyv_pkg::REG_GREEN_MASK:
                begin
                    cfg_reg.green_bits <= pwdata;
                    cfg_reg.green_tz   <= mpyuyv_pkg::trailing_zeros(pwdata);
                end
                mpyuyv_pkg::REG_BLUE_MASK:
                begin
                    cfg_reg.blue_bits <= pwdata;
                    cfg_reg.blue_tz   <= mpyuyv_pkg::trailing_zeros(pwdata);
                end
                mpyuyv_pkg::REG_FORMAT:
                begin
                    cfg_reg.output_format <= pwdata[1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Return the addressed register, zero past the end
    always_comb
    begin
        unique case (index)
            mpyuyv_pkg::REG_BPP:        prdata = {29'd0, cfg_reg.bytes_per_pixel};
            mpyuyv_pkg::REG_BIG_ENDIAN: prdata = {31'd0, cfg_reg.big_endian};
            mpyuyv_pkg::REG_RED_MASK:   prdata = cfg_reg.red_bits;
            mpyuyv_pkg::REG_GREEN_MASK: prdata = cfg_reg.green_bits;
            mpyuyv_pkg::REG_BLUE_MASK:  prdata = cfg_reg.blue_bits;
            mpyuyv_pkg::REG_FORMAT:     prdata = {30'd0, cfg_reg.output_format};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

// ----- hdl/masked_pixel_to_yuyv_converter.sv -----
// Top level: four-stage pixel-pair converter to YUYV, RGB24 or BGR24
// Throughput: one pixel pair per clock; busy is never raised.
// The pixels pass through the assemble, channel, weighted sum and clamp/pack
// registers in that order; done is registered alongside them and marks the result.
// The receiver cannot stall, so nothing waits inside the pipe.
// Reset (rst_n low, asynchronous) clears valid bits and restores the configuration registers.
module masked_pixel_to_yuyv_converter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mpyuyv_pkg::AddrWidth-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             start,
    output logic                             busy,
    input  mpyuyv_pkg::pixel_pair_t          pixels,
    output logic                             done,
    output mpyuyv_pkg::yuyv_result_t         result
);

    mpyuyv_pkg::cfg_t cfg;

    // Stage 1: assembled words
    logic        v1_reg;
    logic [31:0] w1_reg, w2_reg;
    logic [1:0]  fmt1_reg;
    // Stage 2: channels
    logic        v2_reg;
    logic [7:0]  r1_reg, g1_reg, b1_reg, r2_reg, g2_reg, b2_reg;
    logic [1:0]  fmt2_reg;
    // Stage 3: weighted sums plus channels carried along
    logic        v3_reg;
    logic signed [17:0] y0_reg, y1_reg, u_reg, v_reg;
    logic [7:0]  r1c_reg, g1c_reg, b1c_reg, r2c_reg, g2c_reg, b2c_reg;
    logic [1:0]  fmt3_reg;
    // Stage 4: output
    logic        done_reg;
    mpyuyv_pkg::yuyv_result_t result_reg, result_next;

    logic signed [17:0] r1s, g1s, b1s, r2s, g2s, b2s;
    logic signed [17:0] y0_next, y1_next, u_next, v_next;
    logic signed [10:0] y0v, y1v, uv, vv;

    mpyuyv_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // Stage 1: assemble raw bytes into pixel words
    always_ff @(posedge clk)
    begin
        w1_reg   <= mpyuyv_pkg::assemble(pixels.raw_first, cfg.bytes_per_pixel,
                                         cfg.big_endian);
        w2_reg   <= mpyuyv_pkg::assemble(pixels.raw_second, cfg.bytes_per_pixel,
                                         cfg.big_endian);
        fmt1_reg <= cfg.output_format;
    end

    // Stage 2: mask and shift out each channel
    always_ff @(posedge clk)
    begin
        r1_reg   <= mpyuyv_pkg::channel(w1_reg, cfg.red_bits, cfg.red_tz);
        g1_reg   <= mpyuyv_pkg::channel(w1_reg, cfg.green_bits, cfg.green_tz);
        b1_reg   <= mpyuyv_pkg::channel(w1_reg, cfg.blue_bits, cfg.blue_tz);
        r2_reg   <= mpyuyv_pkg::channel(w2_reg, cfg.red_bits, cfg.red_tz);
        g2_reg   <= mpyuyv_pkg::channel(w2_reg, cfg.green_bits, cfg.green_tz);
        b2_reg   <= mpyuyv_pkg::channel(w2_reg, cfg.blue_bits, cfg.blue_tz);
        fmt2_reg <= fmt1_reg;
    end

    // Stage 3: BT.601 weighted sums with rounding bias
    assign r1s = $signed({10'd0, r1_reg});
    assign g1s = $signed({10'd0, g1_reg});
    assign b1s = $signed({10'd0, b1_reg});
    assign r2s = $signed({10'd0, r2_reg});
    assign g2s = $signed({10'd0, g2_reg});
    assign b2s = $signed({10'd0, b2_reg});

    assign y0_next = 18'sd66 * r1s + 18'sd129 * g1s + 18'sd25 * b1s + 18'sd128;
    assign y1_next = 18'sd66 * r2s + 18'sd129 * g2s + 18'sd25 * b2s + 18'sd128;
    assign u_next  = 18'sd112 * b1s - 18'sd38 * r1s - 18'sd74 * g1s + 18'sd128;
    assign v_next  = 18'sd112 * r1s - 18'sd94 * g1s - 18'sd18 * b1s + 18'sd128;

    always_ff @(posedge clk)
    begin
        y0_reg   <= y0_next;
        y1_reg   <= y1_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        r1c_reg  <= r1_reg;
        g1c_reg  <= g1_reg;
        b1c_reg  <= b1_reg;
        r2c_reg  <= r2_reg;
        g2c_reg  <= g2_reg;
        b2c_reg  <= b2_reg;
        fmt3_reg <= fmt2_reg;
    end

    // Stage 4: floor-shift, offset, clamp and pack per format
    assign y0v = 11'(y0_reg >>> 8) + 11'sd16;
    assign y1v = 11'(y1_reg >>> 8) + 11'sd16;
    assign uv  = 11'(u_reg >>> 8) + 11'sd128;
    assign vv  = 11'(v_reg >>> 8) + 11'sd128;

    always_comb
    begin
        unique case (fmt3_reg)
            mpyuyv_pkg::FMT_YUYV:
            begin
                result_next.out_byte0  = mpyuyv_pkg::clamp8(y0v);
                result_next.out_byte1  = mpyuyv_pkg::clamp8(uv);
                result_next.out_byte2  = mpyuyv_pkg::clamp8(y1v);
                result_next.out_byte3  = mpyuyv_pkg::clamp8(vv);
                result_next.out_byte4  = 8'd0;
                result_next.out_byte5  = 8'd0;
                result_next.byte_count = 3'd4;
            end
            mpyuyv_pkg::FMT_BGR24:
            begin
                result_next.out_byte0  = b1c_reg;
                result_next.out_byte1  = g1c_reg;
                result_next.out_byte2  = r1c_reg;
                result_next.out_byte3  = b2c_reg;
                result_next.out_byte4  = g2c_reg;
                result_next.out_byte5  = r2c_reg;
                result_next.byte_count = 3'd6;
            end
            default:
            begin
                result_next.out_byte0  = r1c_reg;
                result_next.out_byte1  = g1c_reg;
                result_next.out_byte2  = b1c_reg;
                result_next.out_byte3  = r2c_reg;
                result_next.out_byte4  = g2c_reg;
                result_next.out_byte5  = b2c_reg;
                result_next.byte_count = 3'd6;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

// ----- hdl/mpyuyv_checker.sv -----
// Port-level checker for the pixel converter, bound to the top level
`include "masked_pixel_to_yuyv_converter_defines.svh"

module mpyuyv_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     done,
    input mpyuyv_pkg::yuyv_result_t result
);

    // Converter never refuses a transaction
    `MPY_ASSERT_IMPL(a_never_busy, 1'b1, !busy)

    // Every accepted transaction yields a result on done
    `MPY_ASSERT_NEXT(a_result_follows, start && !busy, ##3 done)

    // No result without an earlier accepted transaction
    `MPY_ASSERT_IMPL(a_no_spurious, done, $past(start && !busy, 4))

    // Byte count is four or six
    `MPY_ASSERT_IMPL(a_count_legal, done, result.byte_count == 3'd4 || result.byte_count == 3'd6)

    // Short YUYV transactions carry zero padding
    `MPY_ASSERT_IMPL(a_yuyv_pad, done && result.byte_count == 3'd4,
                     result.out_byte4 == 8'd0 && result.out_byte5 == 8'd0)

endmodule

bind masked_pixel_to_yuyv_converter mpyuyv_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the masked pixel-pair to YUYV/RGB24/BGR24 converter
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes past the last register; writes there are ignored
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS   = 1850;
    localparam int MAX_GAP        = 19;
    localparam int PIPE_DEPTH     = 4;
    localparam int WATCHDOG_LIMIT = 400;

    logic                                clk     = 1'b0;
    logic                                rst_n   = 1'b0;
    logic                                psel    = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite  = 1'b0;
    logic [mpyuyv_pkg::AddrWidth-1:0]    paddr   = '0;
    logic [31:0]                         pwdata  = '0;
    logic [31:0]                         prdata;
    logic                                pready;
    logic                                start   = 1'b0;
    logic                                busy;
    mpyuyv_pkg::pixel_pair_t             pixels  = '0;
    logic                                done;
    mpyuyv_pkg::yuyv_result_t            result;

    // Local copy of the converter settings, at reset values
    logic [2:0]  cfg_bpp        = 3'd4;
    logic        cfg_big_endian = 1'b0;
    logic [31:0] cfg_red_bits   = 32'h00FF_0000;
    logic [31:0] cfg_green_bits = 32'h0000_FF00;
    logic [31:0] cfg_blue_bits  = 32'h0000_00FF;
    logic [1:0]  cfg_format     = mpyuyv_pkg::FMT_YUYV;

    mpyuyv_pkg::yuyv_result_t pending_outputs[$];
    mpyuyv_pkg::yuyv_result_t oldest_output;

    int items_sent      = 0;
    int outputs_checked = 0;
    int settings_used   = 0;
    int fail_count      = 0;
    int idle_cycles     = 0;

    masked_pixel_to_yuyv_converter u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .pixels  (pixels),
        .done    (done),
        .result  (result)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Gather the pixel bytes into one word under the current byte settings
    function automatic logic [31:0] gather_word(input logic [31:0] raw);
        int          n;
        int          pos;
        logic [31:0] word;
        n    = (cfg_bpp > 3'd4) ? 4 : int'(cfg_bpp);
        word = '0;
        for (int b = 0; b < n; b++)
        begin
            pos = cfg_big_endian ? (n - 1 - b) : b;
            word[b*8 +: 8] = raw[pos*8 +: 8];
        end
        return word;
    endfunction

    // Number of zero bits below the lowest set bit; zero for an empty mask
    function automatic int mask_shift(input logic [31:0] mask);
        int s;
        s = 0;
        if (mask == '0)
        begin
            return 0;
        end
        while (!mask[s])
        begin
            s++;
        end
        return s;
    endfunction

    function automatic int extract_channel(input logic [31:0] word, input logic [31:0] mask);
        logic [31:0] t;
        t = (word & mask) >> mask_shift(mask);
        return int'(t[7:0]);
    endfunction

    function automatic logic [7:0] saturate8(input int v);
        if (v < 0)
        begin
            return 8'd0;
        end
        if (v > 255)
        begin
            return 8'd255;
        end
        return 8'(v);
    endfunction

    // Expected output bytes for one pixel pair under the current settings
    function automatic mpyuyv_pkg::yuyv_result_t convert_pixels(
        input mpyuyv_pkg::pixel_pair_t pair);
        logic [31:0]              w1;
        logic [31:0]              w2;
        int                       r1, g1, b1, r2, g2, b2;
        mpyuyv_pkg::yuyv_result_t out;
        w1 = gather_word(pair.raw_first);
        w2 = gather_word(pair.raw_second);
        r1 = extract_channel(w1, cfg_red_bits);
        g1 = extract_channel(w1, cfg_green_bits);
        b1 = extract_channel(w1, cfg_blue_bits);
        r2 = extract_channel(w2, cfg_red_bits);
        g2 = extract_channel(w2, cfg_green_bits);
        b2 = extract_channel(w2, cfg_blue_bits);
        if (cfg_format == mpyuyv_pkg::FMT_YUYV)
        begin
            // Arithmetic shift of a signed int floors toward minus infinity
            out.out_byte0  = saturate8(((66 * r1 + 129 * g1 + 25 * b1 + 128) >>> 8) + 16);
            out.out_byte1  = saturate8(((-38 * r1 - 74 * g1 + 112 * b1 + 128) >>> 8) + 128);
            out.out_byte2  = saturate8(((66 * r2 + 129 * g2 + 25 * b2 + 128) >>> 8) + 16);
            out.out_byte3  = saturate8(((112 * r1 - 94 * g1 - 18 * b1 + 128) >>> 8) + 128);
            out.out_byte4  = 8'd0;
            out.out_byte5  = 8'd0;
            out.byte_count = 3'd4;
        end
        else if (cfg_format == mpyuyv_pkg::FMT_BGR24)
        begin
            out.out_byte0  = 8'(b1);
            out.out_byte1  = 8'(g1);
            out.out_byte2  = 8'(r1);
            out.out_byte3  = 8'(b2);
            out.out_byte4  = 8'(g2);
            out.out_byte5  = 8'(r2);
            out.byte_count = 3'd6;
        end
        else
        begin
            // RGB24, and the unused code behaves the same
            out.out_byte0  = 8'(r1);
            out.out_byte1  = 8'(g1);
            out.out_byte2  = 8'(b1);
            out.out_byte3  = 8'(r2);
            out.out_byte4  = 8'(g2);
            out.out_byte5  = 8'(b2);
            out.byte_count = 3'd6;
        end
        return out;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare every result transaction with the oldest pending one
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("result transaction with nothing pending");
                fail_count++;
            end
            else
            begin
                oldest_output = pending_outputs.pop_front();
                check_field("out_byte0", oldest_output.out_byte0, result.out_byte0);
                check_field("out_byte1", oldest_output.out_byte1, result.out_byte1);
                check_field("out_byte2", oldest_output.out_byte2, result.out_byte2);
                check_field("out_byte3", oldest_output.out_byte3, result.out_byte3);
                check_field("out_byte4", oldest_output.out_byte4, result.out_byte4);
                check_field("out_byte5", oldest_output.out_byte5, result.out_byte5);
                check_field("byte_count", 8'(oldest_output.byte_count),
                            8'(result.byte_count));
                outputs_checked++;
            end
        end
    end

    // End the run when nothing moves on any port for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // APB write: setup cycle, then access cycle until pready, then back to idle
    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        case (index)
            mpyuyv_pkg::REG_BPP:        cfg_bpp        = value[2:0];
            mpyuyv_pkg::REG_BIG_ENDIAN: cfg_big_endian = value[0];
            mpyuyv_pkg::REG_RED_MASK:   cfg_red_bits   = value;
            mpyuyv_pkg::REG_GREEN_MASK: cfg_green_bits = value;
            mpyuyv_pkg::REG_BLUE_MASK:  cfg_blue_bits  = value;
            mpyuyv_pkg::REG_FORMAT:     cfg_format     = value[1:0];
            default:                    ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Drop start and hold until every pending result transaction has come back
    task automatic wait_outputs_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_outputs.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Send one pixel pair after any idle gap and record its expected output
    task automatic send_pair(input logic [31:0] first, input logic [31:0] second,
                             input int gap);
        mpyuyv_pkg::pixel_pair_t pair;
        pair.raw_first  = first;
        pair.raw_second = second;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        pixels <= pair;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        pending_outputs.push_back(convert_pixels(pair));
        items_sent++;
    endtask

    task automatic write_all_registers(input logic [2:0] bpp, input logic be,
                                       input logic [31:0] red, input logic [31:0] green,
                                       input logic [31:0] blue, input logic [1:0] fmt);
        wait_outputs_drained();
        write_register(mpyuyv_pkg::REG_BPP, 32'(bpp));
        write_register(mpyuyv_pkg::REG_BIG_ENDIAN, 32'(be));
        write_register(mpyuyv_pkg::REG_RED_MASK, red);
        write_register(mpyuyv_pkg::REG_GREEN_MASK, green);
        write_register(mpyuyv_pkg::REG_BLUE_MASK, blue);
        write_register(mpyuyv_pkg::REG_FORMAT, 32'(fmt));
        settings_used++;
    endtask

    // Reset settings: black, white, primaries and mid gray in YUYV
    task automatic test_reset_yuyv();
        settings_used++;
        send_pair(32'h0000_0000, 32'h0000_0000, 0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_pair(32'h00FF_0000, 32'h0000_FF00, 1);
        send_pair(32'h0000_00FF, 32'h00FF_FFFF, 0);
        send_pair(32'h0080_8080, 32'h1234_5678, 3);
    endtask

    // RGB24, BGR24 and the unused format code
    task automatic test_output_formats();
        write_all_registers(3'd4, 1'b0, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF,
                            mpyuyv_pkg::FMT_RGB24);
        send_pair(32'h00A1_B2C3, 32'h00C3_B2A1, 0);
        wait_outputs_drained();
        write_register(mpyuyv_pkg::REG_FORMAT, 32'(mpyuyv_pkg::FMT_BGR24));
        send_pair(32'h00A1_B2C3, 32'h00C3_B2A1, 0);
        wait_outputs_drained();
        write_register(mpyuyv_pkg::REG_FORMAT, 32'h0000_0003);
        send_pair(32'hDEAD_BEEF, 32'h0102_0304, 0);
    endtask

    // Byte counts zero to five and seven in both byte orders
    task automatic test_byte_assembly();
        write_all_registers(3'd0, 1'b0, 32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000,
                            mpyuyv_pkg::FMT_RGB24);
        send_pair(32'h1122_3344, 32'hA5C3_F00F, 0);
        for (int n = 1; n <= 3; n++)
        begin
            wait_outputs_drained();
            write_register(mpyuyv_pkg::REG_BPP, 32'(n));
            write_register(mpyuyv_pkg::REG_BIG_ENDIAN, 32'(n % 2));
            send_pair(32'h1122_3344, 32'hA5C3_F00F, 0);
        end
        wait_outputs_drained();
        write_register(mpyuyv_pkg::REG_BPP, 32'd4);
        write_register(mpyuyv_pkg::REG_BIG_ENDIAN, 32'd1);
        write_register(mpyuyv_pkg::REG_RED_MASK, 32'hFF00_0000);
        send_pair(32'h1122_3344, 32'hA5C3_F00F, 0);
        // Counts above four saturate
        wait_outputs_drained();
        write_register(mpyuyv_pkg::REG_BPP, 32'd7);
        send_pair(32'h1122_3344, 32'hA5C3_F00F, 0);
        wait_outputs_drained();
        write_register(mpyuyv_pkg::REG_BPP, 32'd5);
        write_register(mpyuyv_pkg::REG_BIG_ENDIAN, 32'd0);
        send_pair(32'h8899_AABB, 32'h7F80_01FE, 0);
    endtask

    // Empty, full, top-bit and sparse masks
    task automatic test_mask_cases();
        write_all_registers(3'd4, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                            mpyuyv_pkg::FMT_YUYV);
        send_pair(32'hFFFF_FFFF, 32'h8000_00FF, 0);
        send_pair(32'h7FFF_FFFF, 32'h0000_0000, 2);
        write_all_registers(3'd4, 1'b1, 32'h00F0_0F00, 32'h0000_0001, 32'hFFFF_FFFF,
                            mpyuyv_pkg::FMT_BGR24);
        send_pair(32'h5A5A_A5A5, 32'hF00F_0FF0, 0);
    endtask

    // Writes past the last register leave the settings untouched
    task automatic test_spare_registers();
        wait_outputs_drained();
        write_register(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_register(REG_SPARE_HI, 32'h0000_0000);
        send_pair(32'h1357_9BDF, 32'hECA8_6420, 0);
        send_pair(32'hFFFF_FFFF, 32'h0000_0000, 0);
    endtask

    function automatic logic [31:0] random_mask();
        int pos;
        int width;
        pos = $urandom_range(0, 31);
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_00FF << $urandom_range(0, 24);
            3:
            begin
                width = $urandom_range(1, 12);
                return 32'((64'(1) << width) - 1) << pos;
            end
            4: return 32'(1) << pos;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_raw();
        case ($urandom_range(0, 15))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Random settings, with stray upper bits on the narrow registers at times
    task automatic apply_random_settings();
        logic [31:0] bpp_word;
        logic [31:0] fmt_word;
        bpp_word = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4)
                                              : ($urandom_range(5, 8) % 8);
        fmt_word = $urandom_range(0, 3);
        if ($urandom_range(0, 1))
        begin
            bpp_word = bpp_word | ($urandom & 32'hFFFF_FFF8);
            fmt_word = fmt_word | ($urandom & 32'hFFFF_FFFC);
        end
        wait_outputs_drained();
        write_register(mpyuyv_pkg::REG_BPP, bpp_word);
        write_register(mpyuyv_pkg::REG_BIG_ENDIAN, $urandom);
        write_register(mpyuyv_pkg::REG_RED_MASK, random_mask());
        write_register(mpyuyv_pkg::REG_GREEN_MASK, random_mask());
        write_register(mpyuyv_pkg::REG_BLUE_MASK, random_mask());
        write_register(mpyuyv_pkg::REG_FORMAT, fmt_word);
        settings_used++;
    endtask

    // Phases of random pixel pairs, each under fresh settings and gap pattern
    task automatic test_random_traffic();
        int sent;
        int phase_len;
        int gap_mode;
        int gap;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            apply_random_settings();
            phase_len = $urandom_range(80, 220);
            gap_mode  = $urandom_range(0, 2);
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++)
            begin
                case (gap_mode)
                    0: gap = 0;
                    1: gap = $urandom_range(0, MAX_GAP);
                    default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
                endcase
                // Now and then let the pipe run empty before the next pair
                if (gap_mode != 0 && $urandom_range(0, 39) == 0)
                begin
                    wait_outputs_drained();
                end
                send_pair(random_raw(), random_raw(), gap);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_yuyv();
        test_output_formats();
        test_byte_assembly();
        test_mask_cases();
        test_spare_registers();
        test_random_traffic();

        wait_outputs_drained();
        repeat (2 * PIPE_DEPTH) @(posedge clk);
        if (pending_outputs.size() != 0)
        begin
            $error("%0d result transactions never arrived", pending_outputs.size());
            fail_count++;
        end

        $display("Sent %0d pixel pairs under %0d register settings, %0d outputs compared",
                 items_sent, settings_used, outputs_checked);
        $display("Formats YUYV/RGB24/BGR24/unused, byte counts 0-7, both byte orders");
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
